/* rtl/core/frx_pkg.sv */
package frx_pkg;

  // frame layout
  localparam int HEADER_BYTES = 11;
  localparam int MAX_FRAME    = 128;
  localparam int POS_W        = $clog2(MAX_FRAME + 1);

  // crc-16/modbus, reflected
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_ACCEPT  = 2'd1;
  localparam logic [1:0] KIND_REJECT  = 2'd2;

  // reject causes
  localparam logic [1:0] CAUSE_NONE    = 2'd0;
  localparam logic [1:0] CAUSE_VERSION = 2'd1;
  localparam logic [1:0] CAUSE_CRC     = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] REG_VERSION     = 2'd2;
  localparam logic [1:0] REG_LIMIT       = 2'd3;

  localparam logic [6:0] LIMIT_RESET = 7'd115;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       flush;
  } frx_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [6:0]  payload_index;
    logic [7:0]  frame_type;
    logic [7:0]  origin_role;
    logic [7:0]  origin_group;
    logic [7:0]  target_role;
    logic [7:0]  target_group;
    logic [15:0] flow_id;
    logic [6:0]  payload_length;
    logic [1:0]  reject_cause;
  } frx_result_t;

  // one byte through the crc, bit by bit, lsb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* rtl/core/frx_in_stage.sv */
module frx_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  frx_pkg::frx_item_t in_item,
  input  logic              take,
  output logic              item_valid,
  output frx_pkg::frx_item_t item
);
  import frx_pkg::*;

  logic      valid_r;
  frx_item_t item_r;
  logic      accept;

  // hold the byte until the parser takes it
  assign in_stall   = valid_r && !take;
  assign accept     = in_valid && !in_stall;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

endmodule

/* rtl/core/frx_parser.sv */
module frx_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic                item_valid,
  input  frx_pkg::frx_item_t  item,
  input  logic                out_ready,
  output logic                fire,
  output logic                emit,
  output frx_pkg::frx_result_t res
);
  import frx_pkg::*;

  localparam logic [POS_W-1:0] OFS_SYNC2   = POS_W'(1);
  localparam logic [POS_W-1:0] OFS_VERSION = POS_W'(2);
  localparam logic [POS_W-1:0] OFS_TYPE    = POS_W'(3);
  localparam logic [POS_W-1:0] OFS_SROLE   = POS_W'(4);
  localparam logic [POS_W-1:0] OFS_SGROUP  = POS_W'(5);
  localparam logic [POS_W-1:0] OFS_DROLE   = POS_W'(6);
  localparam logic [POS_W-1:0] OFS_DGROUP  = POS_W'(7);
  localparam logic [POS_W-1:0] OFS_FLOW_LO = POS_W'(8);
  localparam logic [POS_W-1:0] OFS_FLOW_HI = POS_W'(9);
  localparam logic [POS_W-1:0] OFS_LENGTH  = POS_W'(10);
  localparam logic [POS_W-1:0] POS_HEADER  = POS_W'(HEADER_BYTES);
  localparam logic [POS_W-1:0] POS_MAX     = POS_W'(MAX_FRAME);

  // configuration
  logic [7:0] sync_first_r, sync_second_r, exp_version_r;
  logic [6:0] limit_r;

  // frame state
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       version_r, version_nxt;
  logic [7:0]       type_r, type_nxt;
  logic [7:0]       srole_r, srole_nxt;
  logic [7:0]       sgroup_r, sgroup_nxt;
  logic [7:0]       drole_r, drole_nxt;
  logic [7:0]       dgroup_r, dgroup_nxt;
  logic [15:0]      flow_r, flow_nxt;
  logic [6:0]       len_r, len_nxt;
  logic [7:0]       crc_lo_r, crc_lo_nxt;

  logic [7:0]       b;
  logic [15:0]      crc_upd, crc_start;
  logic [POS_W:0]   pay_end;
  logic [POS_W-1:0] pos_inc, pay_ofs;
  logic [15:0]      crc_got;

  assign fire      = item_valid && out_ready;
  assign b         = item.rx_byte;
  assign crc_upd   = crc_byte(crc_r, b);
  assign crc_start = crc_byte(CRC_INIT, b);
  assign pay_end   = (POS_W+1)'(HEADER_BYTES) + (POS_W+1)'(len_r);
  assign pos_inc   = pos_r + POS_W'(1);
  assign pay_ofs   = pos_r - POS_HEADER;
  assign crc_got   = {b, crc_lo_r};

  // per-byte framing decision
  always_comb begin
    pos_nxt     = pos_r;
    crc_nxt     = crc_r;
    version_nxt = version_r;
    type_nxt    = type_r;
    srole_nxt   = srole_r;
    sgroup_nxt  = sgroup_r;
    drole_nxt   = drole_r;
    dgroup_nxt  = dgroup_r;
    flow_nxt    = flow_r;
    len_nxt     = len_r;
    crc_lo_nxt  = crc_lo_r;
    emit        = 1'b0;

    res                = '0;
    res.frame_type     = type_r;
    res.origin_role    = srole_r;
    res.origin_group   = sgroup_r;
    res.target_role    = drole_r;
    res.target_group   = dgroup_r;
    res.flow_id        = flow_r;
    res.payload_length = len_r;

    priority if (item.flush) begin
      pos_nxt = '0;
      crc_nxt = CRC_INIT;
    end else if (pos_r == '0) begin
      // hunting for the first sync byte
      if (b == sync_first_r) begin
        pos_nxt = OFS_SYNC2;
        crc_nxt = crc_start;
      end
    end else if (pos_r == OFS_SYNC2) begin
      // second sync wins over a repeated first sync
      priority if (b == sync_second_r) begin
        pos_nxt = OFS_VERSION;
        crc_nxt = crc_upd;
      end else if (b == sync_first_r) begin
        crc_nxt = crc_start;
      end else begin
        pos_nxt = '0;
        crc_nxt = CRC_INIT;
      end
    end else if (pos_r >= POS_MAX) begin
      // overlong frame, dropped silently
      pos_nxt = '0;
      crc_nxt = CRC_INIT;
    end else if (pos_r < POS_HEADER) begin
      // header capture
      crc_nxt = crc_upd;
      pos_nxt = pos_inc;
      if (pos_r == OFS_VERSION) version_nxt = b;
      if (pos_r == OFS_TYPE)    type_nxt    = b;
      if (pos_r == OFS_SROLE)   srole_nxt   = b;
      if (pos_r == OFS_SGROUP)  sgroup_nxt  = b;
      if (pos_r == OFS_DROLE)   drole_nxt   = b;
      if (pos_r == OFS_DGROUP)  dgroup_nxt  = b;
      if (pos_r == OFS_FLOW_LO) flow_nxt    = {flow_r[15:8], b};
      if (pos_r == OFS_FLOW_HI) flow_nxt    = {b, flow_r[7:0]};
      if (pos_r == OFS_LENGTH) begin
        len_nxt = b[6:0];
        if (b > {1'b0, limit_r}) begin
          pos_nxt = '0;
          crc_nxt = CRC_INIT;
        end
      end
    end else if ({1'b0, pos_r} < pay_end) begin
      // payload byte goes straight out
      crc_nxt           = crc_upd;
      pos_nxt           = pos_inc;
      emit              = 1'b1;
      res.kind          = KIND_PAYLOAD;
      res.payload_byte  = b;
      res.payload_index = pay_ofs[6:0];
    end else if ({1'b0, pos_r} == pay_end) begin
      crc_lo_nxt = b;
      pos_nxt    = pos_inc;
    end else begin
      // high crc byte: verdict
      emit = 1'b1;
      priority if (version_r != exp_version_r) begin
        res.kind         = KIND_REJECT;
        res.reject_cause = CAUSE_VERSION;
      end else if (crc_got != crc_r) begin
        res.kind         = KIND_REJECT;
        res.reject_cause = CAUSE_CRC;
      end else begin
        res.kind         = KIND_ACCEPT;
        res.reject_cause = CAUSE_NONE;
      end
      pos_nxt = '0;
      crc_nxt = CRC_INIT;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= 8'h00;
      sync_second_r <= 8'h00;
      exp_version_r <= 8'h00;
      limit_r       <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SYNC_FIRST:  sync_first_r  <= cfg_data;
        REG_SYNC_SECOND: sync_second_r <= cfg_data;
        REG_VERSION:     exp_version_r <= cfg_data;
        REG_LIMIT:       limit_r       <= cfg_data[6:0];
      endcase
    end
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      crc_r     <= CRC_INIT;
      version_r <= 8'h00;
      type_r    <= 8'h00;
      srole_r   <= 8'h00;
      sgroup_r  <= 8'h00;
      drole_r   <= 8'h00;
      dgroup_r  <= 8'h00;
      flow_r    <= 16'h0000;
      len_r     <= 7'h00;
      crc_lo_r  <= 8'h00;
    end else if (fire) begin
      pos_r     <= pos_nxt;
      crc_r     <= crc_nxt;
      version_r <= version_nxt;
      type_r    <= type_nxt;
      srole_r   <= srole_nxt;
      sgroup_r  <= sgroup_nxt;
      drole_r   <= drole_nxt;
      dgroup_r  <= dgroup_nxt;
      flow_r    <= flow_nxt;
      len_r     <= len_nxt;
      crc_lo_r  <= crc_lo_nxt;
    end
  end

`ifndef SYNTHESIS
  // position never runs past the frame limit
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_MAX)
    else $error("frame position beyond limit");

  // hunting always starts from a fresh crc
  a_crc_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r == '0 |-> crc_r == CRC_INIT)
    else $error("crc not reset while hunting");

  // a verdict closes the frame
  a_verdict_restart: assert property (@(posedge clk) disable iff (!rst_n)
    fire && emit && res.kind != KIND_PAYLOAD |=> pos_r == '0)
    else $error("no restart after verdict");

  // payload transfers only come from the payload section
  a_payload_pos: assert property (@(posedge clk) disable iff (!rst_n)
    fire && emit && res.kind == KIND_PAYLOAD |-> pos_r >= POS_HEADER)
    else $error("payload emitted inside header");
`endif

endmodule

/* rtl/core/frx_out_stage.sv */
module frx_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  frx_pkg::frx_result_t res,
  output logic                 ready,
  output logic                 out_valid,
  input  logic                 out_stall,
  output frx_pkg::frx_result_t out_res
);
  import frx_pkg::*;

  logic        valid_r;
  frx_result_t res_r;

  // room when empty or when the held result leaves this cycle
  assign ready     = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

/* rtl/core/framed_packet_receiver_crc16_unit.sv */
// Byte-serial frame receiver with CRC-16/MODBUS checking. Bytes enter through an input
// register and are parsed one per cycle while the result register has room: sync hunt,
// 11-byte header, payload bytes forwarded as payload transfers, then one accepted/rejected
// verdict after the little-endian CRC. Sustained rate is one byte per clock while out_stall
// stays low; a byte that produces a result passes the input register and then the result
// register before it shows on the out_ port. The per-cycle path is the eight-bit unrolled
// CRC update feeding the frame state registers. A stalled output holds one result while the
// next byte waits in the input register. Write configuration only while no byte or result
// is held in the block; no clearing pass is needed after reset.
module framed_packet_receiver_crc16_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_flush,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_payload_byte,
  output logic [6:0]  out_payload_index,
  output logic [7:0]  out_frame_type,
  output logic [7:0]  out_origin_role,
  output logic [7:0]  out_origin_group,
  output logic [7:0]  out_target_role,
  output logic [7:0]  out_target_group,
  output logic [15:0] out_flow_id,
  output logic [6:0]  out_payload_length,
  output logic [1:0]  out_reject_cause
);
  import frx_pkg::*;

  frx_item_t   in_item, item;
  logic        item_valid;
  logic        fire, emit, out_ready;
  frx_result_t res, out_res;

  assign in_item.rx_byte = in_rx_byte;
  assign in_item.flush   = in_flush;

  // input register
  frx_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .take       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  // framing, header capture and crc check
  frx_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .out_ready  (out_ready),
    .fire       (fire),
    .emit       (emit),
    .res        (res)
  );

  // result register
  frx_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire && emit),
    .res       (res),
    .ready     (out_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_kind           = out_res.kind;
  assign out_payload_byte   = out_res.payload_byte;
  assign out_payload_index  = out_res.payload_index;
  assign out_frame_type     = out_res.frame_type;
  assign out_origin_role    = out_res.origin_role;
  assign out_origin_group   = out_res.origin_group;
  assign out_target_role    = out_res.target_role;
  assign out_target_group   = out_res.target_group;
  assign out_flow_id        = out_res.flow_id;
  assign out_payload_length = out_res.payload_length;
  assign out_reject_cause   = out_res.reject_cause;

endmodule

/* bench/framed_packet_receiver_crc16_checker.sv */
module framed_packet_receiver_crc16_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_flush,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_kind,
  input  logic [7:0]  out_payload_byte,
  input  logic [6:0]  out_payload_index,
  input  logic [7:0]  out_frame_type,
  input  logic [7:0]  out_origin_role,
  input  logic [7:0]  out_origin_group,
  input  logic [7:0]  out_target_role,
  input  logic [7:0]  out_target_group,
  input  logic [15:0] out_flow_id,
  input  logic [6:0]  out_payload_length,
  input  logic [1:0]  out_reject_cause,
  output int          mismatch_count,
  output int          results_pending
);
  import frx_pkg::*;

  localparam int PRINT_LIMIT = 50;

  // shadow copy of the register file
  logic [7:0] reg_sync_first;
  logic [7:0] reg_sync_second;
  logic [7:0] reg_version;
  logic [6:0] reg_limit;

  // parser state of the modeled receiver
  int unsigned rx_pos;
  logic [15:0] rx_crc;
  logic [7:0]  hdr_version;
  logic [7:0]  hdr_type;
  logic [7:0]  hdr_origin_role;
  logic [7:0]  hdr_origin_group;
  logic [7:0]  hdr_target_role;
  logic [7:0]  hdr_target_group;
  logic [15:0] hdr_flow;
  logic [7:0]  hdr_length;
  logic [7:0]  crc_low;

  // payload bytes and verdicts still owed by the block, oldest first
  frx_result_t frame_results_q[$];

  // modbus crc, one data bit folded in per shift
  function automatic logic [15:0] modbus_crc_update(input logic [15:0] crc,
                                                    input logic [7:0] data);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ data[k];
      c = c >> 1;
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  // header fields carried by every result of the current frame
  function automatic frx_result_t header_result();
    frx_result_t r;
    r = '0;
    r.frame_type     = hdr_type;
    r.origin_role    = hdr_origin_role;
    r.origin_group   = hdr_origin_group;
    r.target_role    = hdr_target_role;
    r.target_group   = hdr_target_group;
    r.flow_id        = hdr_flow;
    r.payload_length = hdr_length[6:0];
    return r;
  endfunction

  task automatic restart_frame();
    rx_pos = 0;
    rx_crc = CRC_INIT;
  endtask

  // advance the receiver by one accepted byte, queueing what it emits
  task automatic take_byte(input logic [7:0] b, input logic fl);
    frx_result_t r;
    logic [15:0] got_crc;
    int unsigned pay_end;
    if (fl) begin
      restart_frame();
      return;
    end
    // sync hunt
    if (rx_pos == 0) begin
      if (b == reg_sync_first) begin
        rx_crc = modbus_crc_update(CRC_INIT, b);
        rx_pos = 1;
      end
      return;
    end
    // second sync wins over a repeated first sync
    if (rx_pos == 1) begin
      if (b == reg_sync_second) begin
        rx_crc = modbus_crc_update(rx_crc, b);
        rx_pos = 2;
      end else if (b == reg_sync_first) begin
        rx_crc = modbus_crc_update(CRC_INIT, b);
      end else begin
        restart_frame();
      end
      return;
    end
    // overlong frame, byte discarded
    if (rx_pos >= MAX_FRAME) begin
      restart_frame();
      return;
    end
    // header collection
    if (rx_pos < HEADER_BYTES) begin
      rx_crc = modbus_crc_update(rx_crc, b);
      case (rx_pos)
        2: hdr_version = b;
        3: hdr_type = b;
        4: hdr_origin_role = b;
        5: hdr_origin_group = b;
        6: hdr_target_role = b;
        7: hdr_target_group = b;
        8: hdr_flow[7:0] = b;
        9: hdr_flow[15:8] = b;
        default: hdr_length = b;
      endcase
      rx_pos++;
      if (rx_pos == HEADER_BYTES && hdr_length > {1'b0, reg_limit}) restart_frame();
      return;
    end
    pay_end = HEADER_BYTES + hdr_length;
    // payload byte forwarded
    if (rx_pos < pay_end) begin
      rx_crc = modbus_crc_update(rx_crc, b);
      r = header_result();
      r.kind          = KIND_PAYLOAD;
      r.payload_byte  = b;
      r.payload_index = 7'(rx_pos - HEADER_BYTES);
      frame_results_q.push_back(r);
      rx_pos++;
      return;
    end
    if (rx_pos == pay_end) begin
      crc_low = b;
      rx_pos++;
      return;
    end
    // crc high byte closes the frame; version check takes priority
    got_crc = {b, crc_low};
    r = header_result();
    if (hdr_version != reg_version) begin
      r.kind         = KIND_REJECT;
      r.reject_cause = CAUSE_VERSION;
    end else if (got_crc != rx_crc) begin
      r.kind         = KIND_REJECT;
      r.reject_cause = CAUSE_CRC;
    end else begin
      r.kind         = KIND_ACCEPT;
      r.reject_cause = CAUSE_NONE;
    end
    frame_results_q.push_back(r);
    restart_frame();
  endtask

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  // config writes, input transfers and result transfers at each edge
  always @(posedge clk) begin : monitor
    frx_result_t got;
    frx_result_t want;
    if (!rst_n) begin
      mismatch_count  = 0;
      reg_sync_first  = 8'h00;
      reg_sync_second = 8'h00;
      reg_version     = 8'h00;
      reg_limit       = LIMIT_RESET;
      restart_frame();
      hdr_version      = '0;
      hdr_type         = '0;
      hdr_origin_role  = '0;
      hdr_origin_group = '0;
      hdr_target_role  = '0;
      hdr_target_group = '0;
      hdr_flow         = '0;
      hdr_length       = '0;
      crc_low          = '0;
      frame_results_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_SYNC_FIRST:  reg_sync_first = cfg_data;
          REG_SYNC_SECOND: reg_sync_second = cfg_data;
          REG_VERSION:     reg_version = cfg_data;
          REG_LIMIT:       reg_limit = cfg_data[6:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) take_byte(in_rx_byte, in_flush);
      if (out_valid && !out_stall) begin
        got.kind           = out_kind;
        got.payload_byte   = out_payload_byte;
        got.payload_index  = out_payload_index;
        got.frame_type     = out_frame_type;
        got.origin_role    = out_origin_role;
        got.origin_group   = out_origin_group;
        got.target_role    = out_target_role;
        got.target_group   = out_target_group;
        got.flow_id        = out_flow_id;
        got.payload_length = out_payload_length;
        got.reject_cause   = out_reject_cause;
        if (frame_results_q.size() == 0) begin
          report_mismatch($sformatf("result transfer kind %0d with none expected", got.kind));
        end else begin
          want = frame_results_q.pop_front();
          check_field("kind", 16'(got.kind), 16'(want.kind));
          check_field("payload_byte", 16'(got.payload_byte), 16'(want.payload_byte));
          check_field("payload_index", 16'(got.payload_index), 16'(want.payload_index));
          check_field("frame_type", 16'(got.frame_type), 16'(want.frame_type));
          check_field("origin_role", 16'(got.origin_role), 16'(want.origin_role));
          check_field("origin_group", 16'(got.origin_group), 16'(want.origin_group));
          check_field("target_role", 16'(got.target_role), 16'(want.target_role));
          check_field("target_group", 16'(got.target_group), 16'(want.target_group));
          check_field("flow_id", got.flow_id, want.flow_id);
          check_field("payload_length", 16'(got.payload_length),
                      16'(want.payload_length));
          check_field("reject_cause", 16'(got.reject_cause), 16'(want.reject_cause));
        end
      end
    end
    results_pending = frame_results_q.size();
  end

endmodule

/* bench/tb_framed_packet_receiver_crc16_unit.sv */
module tb_framed_packet_receiver_crc16_unit;
  import frx_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 65;

  typedef enum int {
    FR_GOOD,
    FR_BAD_VERSION,
    FR_BAD_CRC,
    FR_BAD_BOTH,
    FR_OVER_LIMIT,
    FR_FLUSHED,
    FR_DOUBLE_SYNC,
    FR_BROKEN_SYNC
  } frame_mode_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = '0;
  logic        in_flush = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_payload_byte;
  logic [6:0]  out_payload_index;
  logic [7:0]  out_frame_type;
  logic [7:0]  out_origin_role;
  logic [7:0]  out_origin_group;
  logic [7:0]  out_target_role;
  logic [7:0]  out_target_group;
  logic [15:0] out_flow_id;
  logic [6:0]  out_payload_length;
  logic [1:0]  out_reject_cause;

  int mismatch_count;
  int results_pending;

  // receiver side controls
  logic hold_go = 1'b0;
  logic hold_go_q = 1'b0;
  int   hold_left = 0;
  int   recv_idle_pct = 20;

  // sender side controls and the register values currently programmed
  int         send_idle_pct = 20;
  int         items_sent = 0;
  int         cycle_count = 0;
  logic [7:0] cur_sync_first = 8'h00;
  logic [7:0] cur_sync_second = 8'h00;
  logic [7:0] cur_version = 8'h00;
  logic [6:0] cur_limit = LIMIT_RESET;

  always #2 clk = ~clk;

  framed_packet_receiver_crc16_unit i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .in_flush           (in_flush),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_payload_byte   (out_payload_byte),
    .out_payload_index  (out_payload_index),
    .out_frame_type     (out_frame_type),
    .out_origin_role    (out_origin_role),
    .out_origin_group   (out_origin_group),
    .out_target_role    (out_target_role),
    .out_target_group   (out_target_group),
    .out_flow_id        (out_flow_id),
    .out_payload_length (out_payload_length),
    .out_reject_cause   (out_reject_cause)
  );

  framed_packet_receiver_crc16_checker i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .in_flush           (in_flush),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_payload_byte   (out_payload_byte),
    .out_payload_index  (out_payload_index),
    .out_frame_type     (out_frame_type),
    .out_origin_role    (out_origin_role),
    .out_origin_group   (out_origin_group),
    .out_target_role    (out_target_role),
    .out_target_group   (out_target_group),
    .out_flow_id        (out_flow_id),
    .out_payload_length (out_payload_length),
    .out_reject_cause   (out_reject_cause),
    .mismatch_count     (mismatch_count),
    .results_pending    (results_pending)
  );

  // result side stall: random, or a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_go_q <= 1'b0;
      hold_left <= 0;
    end else begin
      hold_go_q <= hold_go;
      if (hold_go && !hold_go_q) begin
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // crc over a whole frame image, used to build well-formed frames
  function automatic logic [15:0] frame_crc(input logic [7:0] bytes_in[$]);
    logic [15:0] c;
    c = CRC_INIT;
    foreach (bytes_in[i]) begin
      c ^= {8'h00, bytes_in[i]};
      for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // header byte biased toward the extremes
  function automatic logic [7:0] header_byte();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 8'h00;
    if (r < 20) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  // mostly short payloads, sometimes up to the limit
  function automatic int pick_length();
    int r;
    int lim;
    r = $urandom_range(99);
    lim = cur_limit;
    if (r < 4) return lim;
    if (r < 12) return $urandom_range(lim);
    return $urandom_range(lim < 8 ? lim : 8);
  endfunction

  // one input transfer, with an occasional idle gap before it
  task automatic send_item(input logic [7:0] b, input logic fl);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    in_flush   <= fl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [7:0] sf, input logic [7:0] ss,
                              input logic [7:0] ver, input logic [7:0] lim);
    write_reg(REG_SYNC_FIRST, sf);
    write_reg(REG_SYNC_SECOND, ss);
    write_reg(REG_VERSION, ver);
    write_reg(REG_LIMIT, lim);
    cfg_wr_en <= 1'b0;
    cur_sync_first  = sf;
    cur_sync_second = ss;
    cur_version     = ver;
    cur_limit       = lim[6:0];
  endtask

  // stop sending and let every owed result drain
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (results_pending == 0);
    repeat (4) @(posedge clk);
  endtask

  // one frame, well formed or broken as the mode says
  task automatic send_frame(input frame_mode_e mode, input int len, input bit all_ones);
    logic [7:0]  fr[$];
    logic [15:0] crc;
    logic [7:0]  ver;
    logic [7:0]  len_byte;
    logic [7:0]  other;
    int          cut;
    if (mode == FR_BROKEN_SYNC) begin
      do other = 8'($urandom_range(255));
      while (other == cur_sync_first || other == cur_sync_second);
      send_item(cur_sync_first, 1'b0);
      send_item(other, 1'b0);
      return;
    end
    if (mode == FR_DOUBLE_SYNC) send_item(cur_sync_first, 1'b0);
    ver = cur_version;
    if (mode == FR_BAD_VERSION || mode == FR_BAD_BOTH)
      ver = cur_version ^ 8'($urandom_range(255, 1));
    len_byte = (mode == FR_OVER_LIMIT) ? 8'($urandom_range(255, int'(cur_limit) + 1))
                                       : 8'(len);
    fr.push_back(cur_sync_first);
    fr.push_back(cur_sync_second);
    fr.push_back(ver);
    for (int i = 0; i < 7; i++) fr.push_back(all_ones ? 8'hFF : header_byte());
    fr.push_back(len_byte);
    // a dropped frame is followed by a few stray bytes only
    if (mode == FR_OVER_LIMIT) len = $urandom_range(3);
    repeat (len) fr.push_back(8'($urandom_range(255)));
    if (mode != FR_OVER_LIMIT) begin
      crc = frame_crc(fr);
      if (mode == FR_BAD_CRC || mode == FR_BAD_BOTH) crc ^= 16'(1) << $urandom_range(15);
      fr.push_back(crc[7:0]);
      fr.push_back(crc[15:8]);
    end
    cut = (mode == FR_FLUSHED) ? $urandom_range(fr.size() - 1) : fr.size();
    for (int i = 0; i < cut; i++) send_item(fr[i], 1'b0);
    if (mode == FR_FLUSHED) send_item(8'($urandom_range(255)), 1'b1);
  endtask

  // random frame with a little line noise around it
  task automatic random_frame();
    frame_mode_e mode;
    int          r;
    logic [7:0]  noise;
    r = $urandom_range(99);
    if (r < 50)      mode = FR_GOOD;
    else if (r < 58) mode = FR_BAD_VERSION;
    else if (r < 68) mode = FR_BAD_CRC;
    else if (r < 73) mode = FR_BAD_BOTH;
    else if (r < 80) mode = FR_OVER_LIMIT;
    else if (r < 87) mode = FR_FLUSHED;
    else if (r < 95) mode = FR_DOUBLE_SYNC;
    else             mode = FR_BROKEN_SYNC;
    repeat ($urandom_range(2)) begin
      do noise = 8'($urandom_range(255));
      while (noise == cur_sync_first);
      send_item(noise, 1'b0);
    end
    send_frame(mode, pick_length(), 1'b0);
    // resync after frames that can leave the parser mid-frame
    r = $urandom_range(99);
    if ((mode == FR_OVER_LIMIT || mode == FR_BROKEN_SYNC) ? (r < 80) : (r < 10))
      send_item(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic run_phase();
    int start;
    start = items_sent;
    while (items_sent - start < PHASE_ITEMS) random_frame();
    drain();
  endtask

  // stimulus
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: equal sync bytes, all-ones header, empty payload
    send_frame(FR_GOOD, 0, 1'b1);
    send_item(8'h00, 1'b1);
    drain();

    // repeated first sync, stray byte after sync, both-wrong frame
    program_regs(8'hAA, 8'h55, 8'h01, 8'h73);
    send_item(8'hAA, 1'b0);
    send_item(8'hAA, 1'b0);
    send_item(8'h12, 1'b0);
    send_frame(FR_BAD_BOTH, 1, 1'b0);
    drain();

    // back-to-back stretch, no idling on either side
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    run_phase();
    send_idle_pct = 20;
    recv_idle_pct <= 20;

    // equal sync bytes, all-ones version, zero payload limit
    program_regs(8'hFF, 8'hFF, 8'hFF, 8'h00);
    run_phase();

    // widest limit via masked write: hold-off, then an overlong frame
    program_regs(8'h00, 8'hFF, 8'h00, 8'hFF);
    hold_go <= 1'b1;
    send_frame(FR_GOOD, 60, 1'b0);
    hold_go <= 1'b0;
    send_frame(FR_GOOD, 127, 1'b0);
    send_item(8'h00, 1'b1);
    run_phase();

    // random settings
    program_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), 8'($urandom_range(255)));
    run_phase();

    if (mismatch_count == 0 && results_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
